FILE: rtl/bdr_pkg.sv
// Shared types and constants for the button debounce, repeat and chord block.
`default_nettype none

package bdr_pkg;

	localparam int ROWS   = 3;
	localparam int ROW_AW = 2;

	localparam logic [ROW_AW-1:0] ROW_VOL   = 2'd0;
	localparam logic [ROW_AW-1:0] ROW_SKIP  = 2'd1;
	localparam logic [ROW_AW-1:0] ROW_PAUSE = 2'd2;

	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_REPEAT   = 3'd1;
	localparam logic [2:0] REG_ENABLE   = 3'd2;
	localparam logic [2:0] REG_FULL_MV  = 3'd3;
	localparam logic [2:0] REG_LOW_MV   = 3'd4;

	localparam logic [15:0] DEBOUNCE_RST = 16'd50;
	localparam logic [15:0] REPEAT_RST   = 16'd300;
	localparam logic [6:0]  ENABLE_RST   = 7'h7f;
	localparam logic [13:0] FULL_MV_RST  = 14'd4000;
	localparam logic [13:0] LOW_MV_RST   = 14'd3400;

	localparam int EN_UP    = 0;
	localparam int EN_DOWN  = 1;
	localparam int EN_PAUSE = 2;
	localparam int EN_NEXT  = 3;
	localparam int EN_PREV  = 4;
	localparam int EN_RESET = 5;
	localparam int EN_PARTY = 6;

	localparam int PER_W             = 20;
	localparam int CHORD_VOL_PERIODS  = 10;
	localparam int CHORD_SKIP_PERIODS = 3;

	typedef struct packed {
		logic [ROW_AW-1:0] row;
		logic              lvl_a;
		logic              lvl_b;
		logic              rise_a;
		logic              rise_b;
		logic              en_a;
		logic              en_b;
		logic              en_chord;
	} row_ctl_t;

	typedef struct packed {
		logic              valid;
		logic [ROW_AW-1:0] row;
		logic              fire_a;
		logic              fire_b;
		logic              fire_chord;
		logic              pause_busy;
	} row_res_t;

endpackage

`default_nettype wire

FILE: rtl/button_debounce_repeat_chord.sv
// An input beat is registered; its stamp-memory rows (volume pair, skip pair, pause) are
// read and written back one row per cycle, unless the pause row is held, through a
// two-stage update pipeline. A new beat is accepted as the last beat's pause row issues.
// A slow result sink holds the pause row issue until the output register frees.
// Reset clears the registers to their defaults, the time counter and the previous
// button levels; the stamp rows read as zero until first written.
`default_nettype none

module button_debounce_repeat_chord import bdr_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// up_pressed, down_pressed, pause_pressed, next_pressed, previous_pressed, battery_mv
	input  wire logic [23:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// up_command, down_command, pause_command, next_command, previous_command,
	// reset_command, party_command, on_battery, under_voltage
	output logic [15:0]      m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int TB = TIME_BITS;

	logic [15:0]       debounce_q, repeat_q;
	logic [6:0]        enable_q;
	logic [13:0]       full_mv_q, low_mv_q;

	logic              work_valid_q;
	logic [4:0]        levels_q;
	logic [13:0]       mv_q;
	logic [ROW_AW-1:0] phase_q;
	logic [4:0]        prev_levels_q;
	logic [TB-1:0]     tick_q;

	logic [1:0]        flags_q;
	logic [6:0]        acc_q;
	logic              out_valid_q;
	logic [8:0]        out_q;

	logic              out_ok, issue, last_issue, accept;
	logic [4:0]        rises;
	row_ctl_t          ctl;
	logic [4*TB-1:0]   rd_data, wr_data;
	logic              wr_en;
	logic [ROW_AW-1:0] wr_row;
	row_res_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			repeat_q   <= REPEAT_RST;
			enable_q   <= ENABLE_RST;
			full_mv_q  <= FULL_MV_RST;
			low_mv_q   <= LOW_MV_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_REPEAT:   repeat_q   <= cfg_data;
				REG_ENABLE:   enable_q   <= cfg_data[6:0];
				REG_FULL_MV:  full_mv_q  <= cfg_data[13:0];
				REG_LOW_MV:   low_mv_q   <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	assign out_ok        = (!out_valid_q || m_axis_tready) && !res.pause_busy;
	assign issue         = work_valid_q && (phase_q != ROW_PAUSE || out_ok);
	assign last_issue    = issue && phase_q == ROW_PAUSE;
	assign s_axis_tready = !work_valid_q || last_issue;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign rises         = levels_q & ~prev_levels_q;

	always_comb begin
		ctl     = '0;
		ctl.row = phase_q;
		case (phase_q)
			ROW_VOL: begin
				ctl.lvl_a    = levels_q[EN_UP];
				ctl.lvl_b    = levels_q[EN_DOWN];
				ctl.rise_a   = rises[EN_UP];
				ctl.rise_b   = rises[EN_DOWN];
				ctl.en_a     = enable_q[EN_UP];
				ctl.en_b     = enable_q[EN_DOWN];
				ctl.en_chord = enable_q[EN_RESET];
			end
			ROW_SKIP: begin
				ctl.lvl_a    = levels_q[EN_NEXT];
				ctl.lvl_b    = levels_q[EN_PREV];
				ctl.rise_a   = rises[EN_NEXT];
				ctl.rise_b   = rises[EN_PREV];
				ctl.en_a     = enable_q[EN_NEXT];
				ctl.en_b     = enable_q[EN_PREV];
				ctl.en_chord = enable_q[EN_PARTY];
			end
			ROW_PAUSE: begin
				ctl.lvl_a  = levels_q[EN_PAUSE];
				ctl.rise_a = rises[EN_PAUSE];
				ctl.en_a   = enable_q[EN_PAUSE];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q  <= 1'b0;
			phase_q       <= ROW_VOL;
			prev_levels_q <= '0;
			tick_q        <= '0;
		end else begin
			if (accept) begin
				work_valid_q <= 1'b1;
			end else if (last_issue) begin
				work_valid_q <= 1'b0;
			end
			if (issue) begin
				case (phase_q)
					ROW_VOL:   phase_q <= ROW_SKIP;
					ROW_SKIP:  phase_q <= ROW_PAUSE;
					default:   phase_q <= ROW_VOL;
				endcase
			end
			if (last_issue) begin
				prev_levels_q <= levels_q;
				tick_q        <= tick_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			levels_q <= s_axis_tdata[4:0];
			mv_q     <= s_axis_tdata[18:5];
		end
		if (last_issue) begin
			flags_q <= {mv_q < low_mv_q, mv_q < full_mv_q};
		end
	end

	bdr_stamp_mem #(
		.W (4*TB)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (issue),
		.rd_row  (phase_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_row  (wr_row),
		.wr_data (wr_data)
	);

	bdr_row_update #(
		.TB (TB)
	) u_upd (
		.clk         (clk),
		.arst_n      (arst_n),
		.iss_valid   (issue),
		.iss_ctl     (ctl),
		.iss_time    (tick_q),
		.rd_data     (rd_data),
		.debounce_ms (debounce_q),
		.repeat_ms   (repeat_q),
		.wr_en       (wr_en),
		.wr_row      (wr_row),
		.wr_data     (wr_data),
		.res         (res)
	);

	always_ff @(posedge clk) begin
		if (res.valid) begin
			case (res.row)
				ROW_VOL: begin
					acc_q[EN_UP]    <= res.fire_a;
					acc_q[EN_DOWN]  <= res.fire_b;
					acc_q[EN_PAUSE] <= 1'b0;
					acc_q[EN_RESET] <= res.fire_chord;
				end
				ROW_SKIP: begin
					acc_q[EN_NEXT]  <= res.fire_a;
					acc_q[EN_PREV]  <= res.fire_b;
					acc_q[EN_PARTY] <= res.fire_chord;
				end
				ROW_PAUSE: begin
					out_q <= {flags_q, acc_q[6:3], res.fire_a, acc_q[1:0]};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res.row == ROW_PAUSE) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q};

endmodule

`default_nettype wire

FILE: rtl/bdr_stamp_mem.sv
// Stamp memory: one row per button pair and one for pause, registered read, valid bit per row.
`default_nettype none

module bdr_stamp_mem import bdr_pkg::*; #(
	parameter int W = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [ROW_AW-1:0] rd_row,
	output logic      [W-1:0]      rd_data,
	input  wire logic              wr_en,
	input  wire logic [ROW_AW-1:0] wr_row,
	input  wire logic [W-1:0]      wr_data
);

	logic [W-1:0]    mem [ROWS];
	logic [ROWS-1:0] row_valid_q;
	logic [W-1:0]    rd_raw_s1;
	logic            rd_hit_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_s1 <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_hit_s1   <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_s1 <= row_valid_q[rd_row];
			end
		end
	end

	assign rd_data = rd_hit_s1 ? rd_raw_s1 : '0;

endmodule

`default_nettype wire

FILE: rtl/bdr_row_update.sv
// Two-stage row update: press edges, then chord, auto-repeat and pause stamps.
`default_nettype none

module bdr_row_update import bdr_pkg::*; #(
	parameter int TB = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              iss_valid,
	input  wire row_ctl_t          iss_ctl,
	input  wire logic [TB-1:0]     iss_time,
	input  wire logic [4*TB-1:0]   rd_data,
	input  wire logic [15:0]       debounce_ms,
	input  wire logic [15:0]       repeat_ms,
	output logic                   wr_en,
	output logic [ROW_AW-1:0]      wr_row,
	output logic [4*TB-1:0]        wr_data,
	output row_res_t               res
);

	localparam int CW = (TB > PER_W) ? TB : PER_W;

	logic             v_s1;
	row_ctl_t         ctl_s1;
	logic [TB-1:0]    t_s1;

	logic [TB-1:0]    pa, ca, pb, cb;
	logic [TB-1:0]    ela, elb;
	logic             ok_a, ok_b, deb_a, deb_b;
	logic [PER_W-1:0] per;

	logic             v_s2;
	row_ctl_t         ctl_s2;
	logic [TB-1:0]    t_s2;
	logic [TB-1:0]    pa_s2, ca_s2, pb_s2, cb_s2;
	logic             fa_s2, fb_s2;
	logic [PER_W-1:0] per_s2;

	logic [TB-1:0]    later, el_ch, el_ra, el_rb;
	logic             chord_ok, rep_a_ok, rep_b_ok;
	logic [TB-1:0]    pa_n, ca_n, pb_n, cb_n;
	logic             fa_n, fb_n, fc_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= iss_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= iss_ctl;
		t_s1   <= iss_time;
	end

	always_comb begin
		pa    = rd_data[TB-1:0];
		ca    = rd_data[2*TB-1:TB];
		pb    = rd_data[3*TB-1:2*TB];
		cb    = rd_data[4*TB-1:3*TB];
		ela   = t_s1 - pa;
		elb   = t_s1 - pb;
		ok_a  = ctl_s1.rise_a && ctl_s1.en_a;
		ok_b  = ctl_s1.rise_b && ctl_s1.en_b;
		deb_a = CW'(ela) >= CW'(debounce_ms);
		deb_b = CW'(elb) >= CW'(debounce_ms);
		if (ctl_s1.row == ROW_VOL) begin
			per = PER_W'(repeat_ms) * PER_W'(CHORD_VOL_PERIODS);
		end else begin
			per = PER_W'(repeat_ms) * PER_W'(CHORD_SKIP_PERIODS);
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		t_s2   <= t_s1;
		pa_s2  <= ok_a ? t_s1 : pa;
		ca_s2  <= (ok_a && deb_a) ? t_s1 : ca;
		fa_s2  <= ok_a && deb_a;
		pb_s2  <= ok_b ? t_s1 : pb;
		cb_s2  <= (ok_b && deb_b) ? t_s1 : cb;
		fb_s2  <= ok_b && deb_b;
		per_s2 <= per;
	end

	always_comb begin
		later    = (ca_s2 > cb_s2) ? ca_s2 : cb_s2;
		el_ch    = t_s2 - later;
		el_ra    = t_s2 - ca_s2;
		el_rb    = t_s2 - cb_s2;
		chord_ok = CW'(el_ch) > CW'(per_s2);
		rep_a_ok = CW'(el_ra) > CW'(repeat_ms);
		rep_b_ok = CW'(el_rb) > CW'(repeat_ms);
		pa_n = pa_s2;
		ca_n = ca_s2;
		pb_n = pb_s2;
		cb_n = cb_s2;
		fa_n = fa_s2;
		fb_n = fb_s2;
		fc_n = 1'b0;
		if (ctl_s2.row == ROW_PAUSE) begin
			if (ctl_s2.lvl_a) begin
				pa_n = t_s2;
			end
		end else if (ctl_s2.lvl_a && ctl_s2.lvl_b) begin
			pa_n = t_s2;
			pb_n = t_s2;
			if (chord_ok) begin
				ca_n = t_s2;
				fc_n = ctl_s2.en_chord;
			end
		end else if (ctl_s2.lvl_a) begin
			if (ctl_s2.en_a) begin
				pa_n = t_s2;
				if (rep_a_ok) begin
					ca_n = t_s2;
					fa_n = 1'b1;
				end
			end
		end else if (ctl_s2.lvl_b) begin
			if (ctl_s2.en_b) begin
				pb_n = t_s2;
				if (rep_b_ok) begin
					cb_n = t_s2;
					fb_n = 1'b1;
				end
			end
		end
	end

	assign wr_en   = v_s2;
	assign wr_row  = ctl_s2.row;
	assign wr_data = {cb_n, pb_n, ca_n, pa_n};

	always_comb begin
		res.valid      = v_s2;
		res.row        = ctl_s2.row;
		res.fire_a     = fa_n;
		res.fire_b     = fb_n;
		res.fire_chord = fc_n;
		res.pause_busy = (v_s1 && ctl_s1.row == ROW_PAUSE) || (v_s2 && ctl_s2.row == ROW_PAUSE);
	end

endmodule

`default_nettype wire
